FILE: hw/rtl/sct_pkg.sv
`timescale 1ns / 1ps
package sct_pkg;

    // event codes of a result
    localparam logic [2:0] EV_CHAR = 3'd0;
    localparam logic [2:0] EV_END  = 3'd1;
    localparam logic [2:0] EV_EOL  = 3'd2;
    localparam logic [2:0] EV_EOI  = 3'd3;
    localparam logic [2:0] EV_LONG = 3'd4;

    // token kinds
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_QUOTE = 2'd2;

    // character constants
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;

    localparam int LEN_W = 13;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd256;

    // lexer mode, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_OP      = 5'b00100,
        MODE_QUOTE   = 5'b01000,
        MODE_COMMENT = 5'b10000
    } mode_t;

    // one result without its last flag
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] out_char;
        logic [1:0] token_kind;
    } res_t;

    // queue entry: one or two results of one transaction
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } q_entry_t;

    // push from front to back
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

endpackage

FILE: hw/rtl/sct_if.sv
`timescale 1ns / 1ps
interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] out_char;
    logic [1:0] token_kind;
    logic       last_of_run;

    modport source (output valid, output event_res, output out_char, output token_kind,
                    output last_of_run, input ready);
    modport sink (input valid, input event_res, input out_char, input token_kind,
                  input last_of_run, output ready);
endinterface

interface sct_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] max_word_len;

    modport source (output valid, output max_word_len, input ready);
    modport sink (input valid, input max_word_len, output ready);
endinterface

FILE: hw/rtl/sct_front.sv
`timescale 1ns / 1ps
module sct_front (
    input  logic            clk,
    input  logic            rst_n,
    sct_in_if.sink          in_ch,
    sct_cfg_if.sink         cfg,
    input  logic            q_full,
    output sct_pkg::q_push_t q_push
);
    import sct_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] max_len_reg;

    logic       take;
    logic [7:0] c;
    logic       eoi;
    logic       is_blank, is_op7, is_op3;

    // start-of-token outcome
    logic             st_has;
    res_t             st_res;
    mode_t            st_mode;
    logic [LEN_W-1:0] st_len;

    // add-character outcome with the current length
    logic [LEN_W:0]   len_inc;
    logic             ac_long;

    logic [1:0] cnt;
    res_t       r0, r1;

    assign take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !q_full;
    assign cfg.ready = 1'b1;
    assign c = in_ch.in_char;
    assign eoi = in_ch.end_of_input;

    // character classes
    always_comb
    begin
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_op3 = (c == CH_PIPE) || (c == CH_AMP) || (c == CH_GT);
        is_op7 = is_op3 || (c == CH_SEMI) || (c == CH_LT) || (c == CH_LPAR)
                 || (c == CH_RPAR);
    end

    assign len_inc = {1'b0, len_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign ac_long = len_inc >= {1'b0, max_len_reg};

    // start of a new token from idle
    always_comb
    begin
        st_has = 1'b0;
        st_res = '{event_res: EV_EOI, out_char: 8'd0, token_kind: KIND_WORD};
        st_mode = MODE_IDLE;
        st_len = '0;
        if (eoi)
        begin
            st_has = 1'b1;
        end
        else if (is_blank)
        begin
            st_has = (c == CH_NL);
            st_res.event_res = EV_EOL;
        end
        else if (is_op7)
        begin
            st_has = 1'b1;
            st_res = '{event_res: EV_CHAR, out_char: c, token_kind: KIND_OP};
            st_mode = MODE_OP;
        end
        else if (c == CH_QUOTE)
        begin
            st_mode = MODE_QUOTE;
        end
        else if (c == CH_HASH)
        begin
            st_mode = MODE_COMMENT;
        end
        else
        begin
            st_has = 1'b1;
            if (max_len_reg <= {{(LEN_W-1){1'b0}}, 1'b1})
            begin
                st_res = '{event_res: EV_LONG, out_char: 8'd0, token_kind: KIND_WORD};
            end
            else
            begin
                st_res = '{event_res: EV_CHAR, out_char: c, token_kind: KIND_WORD};
                st_mode = MODE_WORD;
                st_len = {{(LEN_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // per-mode classification of the transaction
    always_comb
    begin
        cnt = 2'd0;
        r0 = st_res;
        r1 = st_res;
        mode_next = mode_reg;
        len_next = len_reg;
        case (mode_reg)
            MODE_WORD:
            begin
                if (eoi || is_blank || is_op7 || c == CH_HASH)
                begin
                    r0 = '{event_res: EV_END, out_char: 8'd0, token_kind: KIND_WORD};
                    cnt = st_has ? 2'd2 : 2'd1;
                    mode_next = st_mode;
                    len_next = st_len;
                end
                else if (ac_long)
                begin
                    r0 = '{event_res: EV_LONG, out_char: 8'd0, token_kind: KIND_WORD};
                    cnt = 2'd1;
                    mode_next = MODE_IDLE;
                    len_next = '0;
                end
                else
                begin
                    r0 = '{event_res: EV_CHAR, out_char: c, token_kind: KIND_WORD};
                    cnt = 2'd1;
                    len_next = len_inc[LEN_W-1:0];
                end
            end
            MODE_OP:
            begin
                if (!eoi && is_op3)
                begin
                    r0 = '{event_res: EV_CHAR, out_char: c, token_kind: KIND_OP};
                    r1 = '{event_res: EV_END, out_char: 8'd0, token_kind: KIND_OP};
                    cnt = 2'd2;
                    mode_next = MODE_IDLE;
                    len_next = '0;
                end
                else
                begin
                    r0 = '{event_res: EV_END, out_char: 8'd0, token_kind: KIND_OP};
                    cnt = st_has ? 2'd2 : 2'd1;
                    mode_next = st_mode;
                    len_next = st_len;
                end
            end
            MODE_QUOTE:
            begin
                r0 = '{event_res: EV_END, out_char: 8'd0, token_kind: KIND_QUOTE};
                r1 = '{event_res: EV_EOI, out_char: 8'd0, token_kind: KIND_WORD};
                if (eoi)
                begin
                    cnt = 2'd2;
                    mode_next = MODE_IDLE;
                    len_next = '0;
                end
                else if (c == CH_QUOTE)
                begin
                    cnt = 2'd1;
                    mode_next = MODE_IDLE;
                    len_next = '0;
                end
                else if (ac_long)
                begin
                    r0.event_res = EV_LONG;
                    cnt = 2'd1;
                    mode_next = MODE_IDLE;
                    len_next = '0;
                end
                else
                begin
                    r0 = '{event_res: EV_CHAR, out_char: c, token_kind: KIND_QUOTE};
                    cnt = 2'd1;
                    len_next = len_inc[LEN_W-1:0];
                end
            end
            MODE_COMMENT:
            begin
                len_next = '0;
                if (eoi)
                begin
                    r0 = '{event_res: EV_EOI, out_char: 8'd0, token_kind: KIND_WORD};
                    cnt = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (c == CH_NL)
                begin
                    r0 = '{event_res: EV_EOL, out_char: 8'd0, token_kind: KIND_WORD};
                    cnt = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                r0 = st_res;
                cnt = st_has ? 2'd1 : 2'd0;
                mode_next = st_mode;
                len_next = st_len;
            end
        endcase
    end

    // push to queue
    always_comb
    begin
        q_push.valid = take && (cnt != 2'd0);
        q_push.entry.two = (cnt == 2'd2);
        q_push.entry.r0 = r0;
        q_push.entry.r1 = r1;
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
        end
    end

    // word limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.max_word_len;
        end
    end

`ifndef SYNTHESIS
    a_push_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> in_ch.valid && !q_full)
        else $error("queue push without accepted transaction");
    a_len_zero_outside_token: assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_reg == MODE_WORD || mode_reg == MODE_QUOTE) |-> len_reg == '0)
        else $error("token length nonzero outside word or quote");
    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(mode_reg) && $stable(len_reg))
        else $error("lexer state changed without transaction");
`endif
endmodule

FILE: hw/rtl/sct_back.sv
`timescale 1ns / 1ps
module sct_back #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sct_pkg::q_push_t q_push,
    output logic             q_full,
    sct_out_if.source        out_ch
);
    import sct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    q_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sub_reg, sub_next;

    q_entry_t head;
    res_t     cur;
    logic     last;
    logic     take;
    logic     pop;

    assign head = mem_reg[rd_ptr_reg];
    assign cur = sub_reg ? head.r1 : head.r0;
    assign last = !head.two || sub_reg;
    assign q_full = (count_reg == CNT_FULL);

    // output side
    assign out_ch.valid = (count_reg != '0);
    assign out_ch.event_res = cur.event_res;
    assign out_ch.out_char = cur.out_char;
    assign out_ch.token_kind = cur.token_kind;
    assign out_ch.last_of_run = last;

    assign take = out_ch.valid && out_ch.ready;
    assign pop = take && last;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next = sub_reg;
        if (q_push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            sub_next = !last;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(q_push.valid) - CNT_W'(pop);
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            sub_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
            sub_reg <= sub_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.valid |-> count_reg < CNT_FULL)
        else $error("queue push while full");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");
    a_sub_only_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> out_ch.valid && head.two)
        else $error("second result selected for single-result entry");
`endif
endmodule

FILE: hw/rtl/shell_command_tokenizer.sv
`timescale 1ns / 1ps
// results of an accepted transaction are registered in the result queue and offered in order
// throughput: one input byte per cycle while the queue has room; the output drains one result
//   per cycle while ready; a byte can yield two (operator pair, token end plus next token)
// the result queue between lexer and output holds QUEUE_DEPTH transactions
// reset: mode idle, token length zero, word limit 256, queue empty
module shell_command_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    sct_in_if.sink    in_ch,
    sct_out_if.source out_ch,
    sct_cfg_if.sink   cfg
);
    import sct_pkg::*;

    q_push_t q_push;
    logic    q_full;

    // lexer front end
    sct_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push)
    );

    // result queue and output
    sct_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .out_ch (out_ch)
    );
endmodule
